// ----- hw/rtl/ups2x_pkg.sv -----
package ups2x_pkg;

    // Field and counter widths
    localparam int PIX_W    = 32;
    localparam int CFG_W    = 10;
    localparam int COL_W    = 11;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QLVL_W   = $clog2(QDEPTH + 1);
    localparam int OUT_W    = 152;

    // Channel masks per pixel format
    localparam logic [PIX_W-1:0] MASK_15 = 32'h0000_3DEF;
    localparam logic [PIX_W-1:0] MASK_16 = 32'h0000_7BEF;
    localparam logic [PIX_W-1:0] MASK_32 = 32'h007F_7F7F;

    // Pixel format codes (any other code runs as 32-bit)
    localparam logic [1:0] FMT_15 = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;

    typedef enum logic [1:0] {
        REG_FORMAT  = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_PADDING = 2'd2,
        REG_HEIGHT  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  fmt;
        logic [9:0]  width;
        logic [7:0]  padding;
        logic [9:0]  height;
    } cfg_t;

    // One source cell: its four neighbors and its place in the frame
    typedef struct packed {
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] dr;
        logic [9:0]       col;
        logic [9:0]       row;
        logic             last;
    } block_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              not_empty;
    } q_stat_t;

    function automatic logic is_narrow(input logic [1:0] fmt);
        return (fmt == FMT_15) || (fmt == FMT_16);
    endfunction

    function automatic logic [PIX_W-1:0] fmt_mask(input logic [1:0] fmt);
        logic [PIX_W-1:0] m;
        if (fmt == FMT_15)
        begin
            m = MASK_15;
        end
        else if (fmt == FMT_16)
        begin
            m = MASK_16;
        end
        else
        begin
            m = MASK_32;
        end
        return m;
    endfunction

    function automatic logic [PIX_W-1:0] half(input logic [PIX_W-1:0] p,
                                               input logic [PIX_W-1:0] mask);
        return (p >> 1) & mask;
    endfunction

endpackage

// ----- hw/rtl/ups2x_ram.sv -----
module ups2x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ups2x_front.sv -----
module ups2x_front #(
    parameter int MAX_LINE = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ups2x_pkg::cfg_t         cfg,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,
    input  logic                    s_tuser,
    input  ups2x_pkg::q_stat_t      q_stat,
    output logic                    push_valid,
    output ups2x_pkg::block_t       push_blk
);
    import ups2x_pkg::*;

    localparam int AW = $clog2(MAX_LINE);

    logic             accept;
    logic [PIX_W-1:0] pix_in;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] stride;
    logic [COL_W-1:0] col_inc;
    logic [COL_W-1:0] col_dec;
    logic [COL_W-1:0] row_dec;
    logic             wrap;
    logic             emit;
    logic             in_store;
    logic             last;
    logic [COL_W+AW-1:0] col_ext;
    logic [AW-1:0]    addr;
    logic [PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0] above;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [COL_W-1:0] row_count_reg, row_count_next;
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_emit_reg;
    logic             s1_instore_reg;
    logic [9:0]       s1_col_reg;
    logic [9:0]       s1_row_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] upper_left_reg;

    // Take a request only if the queue can hold it and the one in flight
    assign s_tready = ({1'b0, q_stat.level} + {{QLVL_W{1'b0}}, s1_valid_reg})
                      < (QLVL_W + 1)'(QDEPTH);
    assign accept   = s_tvalid & s_tready;

    // Classify the incoming pixel
    always_comb
    begin
        pix_in   = is_narrow(cfg.fmt) ? {16'h0000, s_tdata[15:0]} : s_tdata;
        col      = s_tuser ? '0 : col_count_reg;
        row      = s_tuser ? '0 : row_count_reg;
        stride   = {1'b0, cfg.width} + {3'b000, cfg.padding};
        col_inc  = col + 11'd1;
        col_dec  = col - 11'd1;
        row_dec  = row - 11'd1;
        wrap     = (stride == '0) || (col_inc >= stride);
        emit     = (row != '0) && (row <= {1'b0, cfg.height})
                   && (col != '0) && (col <= {1'b0, cfg.width});
        last     = (col == {1'b0, cfg.width}) && (row == {1'b0, cfg.height});
        in_store = 32'(col) < MAX_LINE;
        col_ext  = {{AW{1'b0}}, col};
        addr     = col_ext[AW-1:0];
    end

    // Advance the column and row counters
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (wrap)
            begin
                col_count_next = '0;
                row_count_next = (row <= {1'b0, cfg.height}) ? row + 11'd1 : row;
            end
            else
            begin
                col_count_next = col_inc;
                row_count_next = row;
            end
        end
    end

    ups2x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .clk   (clk),
        .we    (accept & in_store),
        .waddr (addr),
        .wdata (pix_in),
        .re    (accept),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= accept;
            if (s1_valid_reg)
            begin
                upper_left_reg <= above;
                left_reg       <= s1_pix_reg;
            end
        end
    end

    // Hold the classified pixel while the line store read completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= pix_in;
            s1_emit_reg    <= emit;
            s1_instore_reg <= in_store;
            s1_col_reg     <= col_dec[9:0];
            s1_row_reg     <= row_dec[9:0];
            s1_last_reg    <= last;
        end
    end

    // Gather the cell and push it when it produces a block
    always_comb
    begin
        above         = s1_instore_reg ? ram_rdata : '0;
        push_valid    = s1_valid_reg & s1_emit_reg;
        push_blk.c    = upper_left_reg;
        push_blk.r    = above;
        push_blk.d    = left_reg;
        push_blk.dr   = s1_pix_reg;
        push_blk.col  = s1_col_reg;
        push_blk.row  = s1_row_reg;
        push_blk.last = s1_last_reg;
    end

endmodule

// ----- hw/rtl/ups2x_queue.sv -----
module ups2x_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    input  ups2x_pkg::block_t       push_blk,
    input  logic                    pop,
    output ups2x_pkg::block_t       head_blk,
    output ups2x_pkg::q_stat_t      q_stat
);
    import ups2x_pkg::*;

    block_t             entries_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0]  level_reg, level_next;

    // Move pointers and fill level
    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + QLVL_W'(push_valid) - QLVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entries_reg[wr_ptr_reg] <= push_blk;
        end
    end

    assign head_blk         = entries_reg[rd_ptr_reg];
    assign q_stat.level     = level_reg;
    assign q_stat.not_empty = level_reg != '0;

endmodule

// ----- hw/rtl/ups2x_back.sv -----
module ups2x_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              fmt,
    input  ups2x_pkg::q_stat_t      q_stat,
    input  ups2x_pkg::block_t       head_blk,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [151:0]            m_tdata,
    output logic                    m_tlast
);
    import ups2x_pkg::*;

    logic [PIX_W-1:0] mask;
    logic [PIX_W-1:0] wmask;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] lower;
    logic [PIX_W-1:0] br;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] tl_reg;
    logic [PIX_W-1:0] tr_reg;
    logic [PIX_W-1:0] bl_reg;
    logic [PIX_W-1:0] br_reg;
    logic [9:0]       col_reg;
    logic [9:0]       row_reg;
    logic             last_reg;

    // Take the head when the output register is free or being drained
    assign pop = q_stat.not_empty && (!out_valid_reg || m_tready);

    // Average the cell neighbors
    always_comb
    begin
        mask  = fmt_mask(fmt);
        wmask = is_narrow(fmt) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        tr    = half(head_blk.c, mask) + half(head_blk.r, mask);
        bl    = half(head_blk.c, mask) + half(head_blk.d, mask);
        lower = half(head_blk.d, mask) + half(head_blk.dr, mask);
        br    = half(tr, mask) + half(lower, mask);
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output block
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tl_reg   <= head_blk.c & wmask;
            tr_reg   <= tr & wmask;
            bl_reg   <= bl & wmask;
            br_reg   <= br & wmask;
            col_reg  <= head_blk.col;
            row_reg  <= head_blk.row;
            last_reg <= head_blk.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, row_reg, col_reg, br_reg, bl_reg, tr_reg, tl_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/pixel_upscale_2x_interpolated_core.sv -----
// 2x bilinear upscaler, streaming.
// Input channel (s_*): one source pixel per request in raster order; s_tuser
// marks the first pixel of a frame. Each line carries active_width +
// line_padding pixels, and active_height + 1 lines make a frame.
// Output channel (m_*): one 2x2 block per source cell (x,y), produced when
// pixel (x+1,y+1) arrives; m_tlast flags the last block of the frame.
// Configuration: write cfg_wdata to register cfg_addr (0 format, 1 width,
// 2 padding, 3 height) while no pixel is in flight.
// Throughput: one pixel per clock while s_tready is high; each pixel takes a
// single read and at most a single write of the line store, which sets the rate.
// Path: the pixel completing a block passes the line store read stage, the
// block waits in the queue, then loads into the output register.
// Reset: counters clear, the neighbor registers clear, registers load their
// defaults (16-bit format, 320 x 240, padding 16). The line store is not
// cleared; the first line of each frame fills it.
// Stall: a four-entry queue sits between the classifier and the averaging
// stage; s_tready drops once the queued blocks plus the pixel in the line
// store read stage reach four.
module pixel_upscale_2x_interpolated_core #(
    parameter int MAX_LINE = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] src_pixel
    input  logic         s_tuser,   // [0] start_of_frame
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // top_left, top_right, bottom_left,
                                    // bottom_right, block_col, block_row, zero fill
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [9:0]   cfg_wdata
);
    import ups2x_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    logic    push_valid;
    block_t  push_blk;
    block_t  head_blk;
    logic    pop;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_FORMAT:  cfg_next.fmt     = cfg_wdata[1:0];
                REG_WIDTH:   cfg_next.width   = cfg_wdata;
                REG_PADDING: cfg_next.padding = cfg_wdata[7:0];
                REG_HEIGHT:  cfg_next.height  = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt     <= FMT_16;
            cfg_reg.width   <= 10'd320;
            cfg_reg.padding <= 8'd16;
            cfg_reg.height  <= 10'd240;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ups2x_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_blk   (push_blk)
    );

    ups2x_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_blk   (push_blk),
        .pop        (pop),
        .head_blk   (head_blk),
        .q_stat     (q_stat)
    );

    ups2x_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .fmt      (cfg_reg.fmt),
        .q_stat   (q_stat),
        .head_blk (head_blk),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (q_stat.level != QLVL_W'(QDEPTH)))
        else $error("block pushed into full queue");

    // A push always comes in the cycle after an accepted pixel
    a_push_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> $past(s_tvalid && s_tready))
        else $error("block pushed without an accepted pixel");

    // The back end pops only a filled queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.not_empty)
        else $error("pop from empty queue");
`endif

endmodule
